// ===== design/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by the store, the top level and the port checker; depends on nothing.
package lkvc_pkg;

  // Store geometry
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_BITS = 32;

  // Field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [IDX_W-1:0]    rank_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // One request beat handed from the input register to the store
  typedef struct packed {
    logic                     fire;
    logic                     op;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // Lookup result for a get
  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] data;
  } rsp_t;

endpackage

// ===== design/lkvc_store.sv =====
// Entry store of the LRU cache: keys, data, valid marks, recency ranks,
// occupancy and capacity, with the parallel compare and rank update.
// Depends on lkvc_pkg.
module lkvc_store (
  input  logic                        clk,
  input  logic                        rst,
  input  lkvc_pkg::req_t              req,
  input  logic                        cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wdata,
  output lkvc_pkg::rsp_t              rsp
);

  logic                                  entry_valid [lkvc_pkg::ENTRIES];
  lkvc_pkg::key_t                        entry_key   [lkvc_pkg::ENTRIES];
  logic signed [lkvc_pkg::DATA_W-1:0]    entry_data  [lkvc_pkg::ENTRIES];
  lkvc_pkg::rank_t                       rank        [lkvc_pkg::ENTRIES];
  lkvc_pkg::cnt_t                        occupancy;
  logic [lkvc_pkg::CAP_W-1:0]            capacity;

  lkvc_pkg::key_t  req_key;
  logic            hit_any;
  lkvc_pkg::idx_t  hit_idx;
  lkvc_pkg::idx_t  free_idx;
  lkvc_pkg::idx_t  victim_idx;
  lkvc_pkg::cnt_t  eff_cap;
  lkvc_pkg::cnt_t  occ_last;
  logic            full;
  lkvc_pkg::idx_t  target;
  lkvc_pkg::cnt_t  old_rank;
  logic            do_update;
  logic            do_write;
  logic            do_insert;

  // Sign-extend or trim the incoming key to the compare width
  assign req_key = lkvc_pkg::key_t'(req.key);

  // Clamp capacity into 1 .. ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = lkvc_pkg::cnt_t'(1);
    end else if (lkvc_pkg::CNT_W'(capacity) > lkvc_pkg::cnt_t'(lkvc_pkg::ENTRIES)) begin
      eff_cap = lkvc_pkg::cnt_t'(lkvc_pkg::ENTRIES);
    end else begin
      eff_cap = lkvc_pkg::CNT_W'(capacity);
    end
  end

  assign occ_last = occupancy - lkvc_pkg::cnt_t'(1);
  assign full     = (occupancy >= eff_cap);

  // Compare every valid entry; lowest match and lowest free slot win
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == req_key) begin
        hit_any = 1'b1;
        hit_idx = lkvc_pkg::idx_t'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = lkvc_pkg::idx_t'(i);
      end
    end
  end

  // Least recent valid entry; the last one in slot order wins
  always_comb begin
    victim_idx = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (entry_valid[i] && lkvc_pkg::CNT_W'(rank[i]) == occ_last) begin
        victim_idx = lkvc_pkg::idx_t'(i);
      end
    end
  end

  // Pick the slot that becomes most recent and the rank it leaves behind
  always_comb begin
    priority if (hit_any) begin
      target   = hit_idx;
      old_rank = lkvc_pkg::CNT_W'(rank[hit_idx]);
    end else if (full) begin
      target   = victim_idx;
      old_rank = occ_last;
    end else begin
      target   = free_idx;
      old_rank = occupancy;
    end
  end

  assign do_write  = req.fire && (req.op == lkvc_pkg::OP_SET);
  assign do_update = do_write || (req.fire && hit_any);
  assign do_insert = do_write && !hit_any && !full;

  // Result of a get
  assign rsp.hit  = hit_any;
  assign rsp.data = hit_any ? entry_data[hit_idx] : '1;

  // Valid marks, ranks and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
        rank[i]        <= '0;
      end
    end else if (do_update) begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (target == lkvc_pkg::idx_t'(i)) begin
          rank[i] <= '0;
        end else if (entry_valid[i] && lkvc_pkg::CNT_W'(rank[i]) < old_rank) begin
          rank[i] <= rank[i] + lkvc_pkg::rank_t'(1);
        end
      end
      if (do_insert) begin
        entry_valid[target] <= 1'b1;
        occupancy           <= occupancy + lkvc_pkg::cnt_t'(1);
      end
    end
  end

  // Key and data storage
  always_ff @(posedge clk) begin
    if (do_write) begin
      entry_key[target]  <= req_key;
      entry_data[target] <= req.value;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: input register, result register
// and handshake control around the entry store. Depends on lkvc_pkg, lkvc_store.
//
// Usage:
//   Input channel: in_valid / in_stall with op, key, value. A beat is taken at
//   a rising edge with in_valid high and in_stall low. op = get looks up key,
//   op = set writes value under key (evicting the least recent entry when the
//   store holds capacity entries).
//   Output channel: out_valid / out_stall with hit, read_value. One beat per
//   get, none per set; read_value is all ones on a miss.
//   Configuration: cfg_we / cfg_wdata write the capacity (1..16, reset 16);
//   write it only while no request is in flight.
// A get's result shows once it has passed the input and result registers.
// Throughput: one request per cycle unless a get meets a stalled result; each
//   reads and updates the whole store from the input register; the next sees it.
// Reset (rst, synchronous): all entries invalid, occupancy zero, both
//   channels empty.
// Stall: a result waiting under out_stall holds; further sets still proceed,
//   and a get waits in the input register, raising in_stall.
module lru_key_value_cache (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   key,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  output logic signed [lkvc_pkg::DATA_W-1:0]  read_value,
  input  logic                                cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata
);

  logic                                in_full;
  logic                                in_full_next;
  logic                                op_q;
  logic signed [lkvc_pkg::KEY_W-1:0]   key_q;
  logic signed [lkvc_pkg::DATA_W-1:0]  value_q;
  logic                                in_take;
  logic                                fire;
  logic                                load_out;
  logic                                out_valid_next;
  lkvc_pkg::req_t                      req;
  lkvc_pkg::rsp_t                      rsp;

  // Advance the held request unless it is a get and the result slot is blocked
  assign fire     = in_full && (op_q == lkvc_pkg::OP_SET || !out_valid || !out_stall);
  assign in_stall = in_full && !fire;
  assign in_take  = in_valid && !in_stall;
  assign load_out = fire && (op_q == lkvc_pkg::OP_GET);

  assign req.fire  = fire;
  assign req.op    = op_q;
  assign req.key   = key_q;
  assign req.value = value_q;

  lkvc_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (rsp)
  );

  // Input register occupancy
  always_comb begin
    if (in_take) begin
      in_full_next = 1'b1;
    end else if (fire) begin
      in_full_next = 1'b0;
    end else begin
      in_full_next = in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q    <= op;
      key_q   <= key;
      value_q <= value;
    end
  end

  // Result register: load on a get, hold while stalled, drop once taken
  assign out_valid_next = load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit        <= rsp.hit;
      read_value <= rsp.data;
    end
  end

endmodule

// ===== design/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                hit,
  input logic signed [lkvc_pkg::DATA_W-1:0]  read_value
);

  // Output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value))
    else $error("result beat changed under stall");

  // A miss always reads all ones
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == '1)
    else $error("miss result not all ones");

  // Input side only stalls while the result slot is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with free result slot");

  // Reset empties the output channel
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ===== tb/lru_key_value_cache_tb.sv =====
// Testbench for lru_key_value_cache: directed and random gets and sets under random
// idling, with an in-house LRU predictor checking each lookup result.
// Depends on lkvc_pkg and lru_key_value_cache.
module lru_key_value_cache_tb;

  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int DRAIN_LIMIT   = 4000;
  localparam logic signed [lkvc_pkg::KEY_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [lkvc_pkg::KEY_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                               hit;
    logic signed [lkvc_pkg::DATA_W-1:0] data;
  } lookup_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               op = lkvc_pkg::OP_GET;
  logic signed [lkvc_pkg::KEY_W-1:0]  key = '0;
  logic signed [lkvc_pkg::DATA_W-1:0] value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               hit;
  logic signed [lkvc_pkg::DATA_W-1:0] read_value;
  logic                               cfg_we = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata = lkvc_pkg::CAP_RESET;

  // Predictor state: the cache contents as the block should hold them
  bit                                 slot_valid[lkvc_pkg::ENTRIES];
  lkvc_pkg::key_t                     slot_key[lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0]        slot_data[lkvc_pkg::ENTRIES];
  int                                 slot_rank[lkvc_pkg::ENTRIES];
  int                                 occupancy = 0;
  int                                 capacity = int'(lkvc_pkg::CAP_RESET);

  lookup_t                            pending_lookups[$];
  logic signed [lkvc_pkg::KEY_W-1:0]  key_pool[$];
  int                                 errors = 0;
  int                                 items_sent = 0;
  int                                 rx_wait = 0;
  int                                 long_hold = 0;
  bit                                 tx_quiet = 1'b0;
  bit                                 rx_quiet = 1'b0;

  lru_key_value_cache dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Bound the run
  initial begin
    #3000000;
    $display("lru_key_value_cache test failed");
    $finish;
  end

  function automatic int gap_draw(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Age every valid slot more recent than old_rank, then make slot s the newest
  function automatic void make_recent(int s, int old_rank);
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one access to the predicted cache; returns the lookup a get should give
  function automatic lookup_t cache_access(input logic o,
                                           input logic signed [lkvc_pkg::KEY_W-1:0] k,
                                           input logic signed [lkvc_pkg::DATA_W-1:0] v);
    lkvc_pkg::key_t kk;
    int             slot;
    int             victim;
    int             eff_cap;
    lookup_t        r;
    kk = lkvc_pkg::key_t'(k);
    slot = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (slot < 0 && slot_valid[i] && slot_key[i] == kk) slot = i;
    end
    eff_cap = (capacity == 0) ? 1 :
              (capacity > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : capacity;
    r.hit  = 1'b0;
    r.data = '1;
    if (o == lkvc_pkg::OP_GET) begin
      if (slot >= 0) begin
        make_recent(slot, slot_rank[slot]);
        r.hit  = 1'b1;
        r.data = slot_data[slot];
      end
    end else if (slot >= 0) begin
      slot_data[slot] = v;
      make_recent(slot, slot_rank[slot]);
    end else if (occupancy >= eff_cap && occupancy > 0) begin
      // Full: reuse the least recent slot
      victim = 0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (slot_valid[i] && slot_rank[i] == occupancy - 1) victim = i;
      end
      slot_key[victim]  = kk;
      slot_data[victim] = v;
      make_recent(victim, occupancy - 1);
    end else begin
      // Take the first free slot as the newest entry
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (slot < 0 && !slot_valid[i]) slot = i;
      end
      for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
        if (slot_valid[j]) slot_rank[j]++;
      end
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = kk;
      slot_data[slot]  = v;
      slot_rank[slot]  = 0;
      occupancy++;
    end
    return r;
  endfunction

  // Check result beats, predict request beats and track capacity writes
  always @(posedge clk) begin : monitor
    lookup_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result beat with no lookup pending", read_value, '0);
        end else begin
          want = pending_lookups.pop_front();
          if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
          if (read_value !== want.data) report_mismatch("read_value", read_value, want.data);
        end
        rx_wait = gap_draw(rx_quiet);
      end
      if (in_valid && !in_stall) begin
        want = cache_access(op, key, value);
        if (op == lkvc_pkg::OP_GET) pending_lookups.push_back(want);
      end
      if (cfg_we) capacity = int'(cfg_wdata);
    end
  end

  // Drive the result stall: a long hold when asked, else the drawn wait
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1'b1;
        long_hold--;
      end else if (rx_wait > 0) begin
        out_stall = 1'b1;
        rx_wait--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one request beat after a drawn gap and hold it until taken
  task automatic send_beat(logic o, logic signed [lkvc_pkg::KEY_W-1:0] k,
                           logic signed [lkvc_pkg::DATA_W-1:0] v);
    int gap;
    gap = gap_draw(tx_quiet);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      key = $urandom;
      value = $urandom;
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = o;
    key = k;
    value = v;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait until every lookup has been answered
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_lookups.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(int c);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = lkvc_pkg::CAP_W'(c);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic build_pool(int n);
    key_pool.delete();
    repeat (n) begin
      case ($urandom_range(0, 11))
        0:       key_pool.push_back(WORD_MIN);
        1:       key_pool.push_back(WORD_MAX);
        2:       key_pool.push_back(-32'sd1);
        3:       key_pool.push_back(32'sd0);
        default: key_pool.push_back($urandom);
      endcase
    end
  endtask

  function automatic logic signed [lkvc_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 24) == 0) return $urandom;
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic send_random(int n, int get_pct);
    repeat (n) begin
      if ($urandom_range(0, 29) == 0) tx_quiet = ~tx_quiet;
      if ($urandom_range(0, 29) == 0) rx_quiet = ~rx_quiet;
      send_beat(($urandom_range(1, 100) <= get_pct) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_SET,
                pick_key(), $urandom);
    end
  endtask

  // Extremes, update in place, and eviction after capacity drops below occupancy
  task automatic test_directed();
    send_beat(lkvc_pkg::OP_GET, 32'sd0, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, WORD_MIN, WORD_MAX);
    send_beat(lkvc_pkg::OP_SET, WORD_MIN, WORD_MAX);
    send_beat(lkvc_pkg::OP_SET, WORD_MAX, WORD_MIN);
    send_beat(lkvc_pkg::OP_SET, -32'sd1, 32'sd0);
    send_beat(lkvc_pkg::OP_SET, 32'sd0, -32'sd1);
    send_beat(lkvc_pkg::OP_GET, WORD_MIN, -32'sd1);
    send_beat(lkvc_pkg::OP_GET, WORD_MAX, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, -32'sd1, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, 32'sd0, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, 32'sd1, 32'sd0);
    send_beat(lkvc_pkg::OP_SET, 32'sd0, 32'sh1234_5678);
    send_beat(lkvc_pkg::OP_GET, 32'sd0, 32'sd0);
    // Four entries held; shrink to one and let sets evict the oldest
    set_capacity(1);
    send_beat(lkvc_pkg::OP_SET, 32'sd5, 32'sd55);
    send_beat(lkvc_pkg::OP_GET, WORD_MIN, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, 32'sd5, 32'sd0);
    send_beat(lkvc_pkg::OP_SET, 32'sd6, 32'sd66);
    send_beat(lkvc_pkg::OP_GET, WORD_MAX, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, 32'sd6, 32'sd0);
    send_beat(lkvc_pkg::OP_GET, 32'sd5, 32'sd0);
    set_capacity(16);
    send_beat(lkvc_pkg::OP_SET, 32'sd7, 32'sd77);
    send_beat(lkvc_pkg::OP_GET, 32'sd7, 32'sd0);
  endtask

  // Phases of random traffic, each with its own capacity and key pool
  task automatic test_random_phases();
    int phase;
    int cap;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      cap = (phase == 0) ? 16 : (phase == 1) ? 1 : $urandom_range(1, 16);
      set_capacity(cap);
      build_pool(cap + $urandom_range(0, cap + 4));
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      send_random($urandom_range(40, 120), $urandom_range(30, 70));
      phase++;
    end
    set_capacity(16);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Hold the result side off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    build_pool(20);
    tx_quiet = 1'b1;
    long_hold = 250;
    send_random(70, 75);
    tx_quiet = 1'b0;
  endtask

  // Pause the request side until every lookup has come back, then resume
  task automatic test_drain_pause();
    send_random(40, 50);
    wait_idle();
    send_random(40, 50);
  endtask

  initial begin : stimulus
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_data[i]  = '0;
      slot_rank[i]  = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phases();
    test_output_backpressure();
    test_drain_pause();

    // Let the last results arrive, then settle
    @(negedge clk);
    in_valid = 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_lookups.size() > 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (pending_lookups.size() > 0)
      report_mismatch("lookups never answered", 32'(pending_lookups.size()), '0);
    if (errors == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
